// ----- rtl/iisb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package iisb_pkg;

    // Depth of the list
    localparam int unsigned CAPACITY = 256;
    localparam int unsigned ADDR_W   = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int unsigned OP_W     = 2;
    localparam int unsigned IDX_W    = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ECOUNT_W = 9;

    // Width that holds both an index and a count for comparison
    localparam int unsigned CMP_W    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [IDX_W-1:0]         slot_index;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] removed_value;
        logic [ECOUNT_W-1:0]      element_count;
    } out_item_t;

    // Access request from the sequencer to the word store
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

endpackage

`default_nettype wire

// ----- rtl/iisb_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module iisb_store (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire iisb_pkg::store_req_t          req,
    output logic [iisb_pkg::WORD_W-1:0]        rd_data
);

    logic [iisb_pkg::WORD_W-1:0]   mem_reg [iisb_pkg::CAPACITY];
    logic [iisb_pkg::CAPACITY-1:0] written_reg;
    logic [iisb_pkg::WORD_W-1:0]   data_reg;
    logic                          hit_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            data_reg <= mem_reg[req.rd_addr];
        end
    end

    // Entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            if (req.wr_en) begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                hit_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/iisb_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module iisb_seq (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire iisb_pkg::in_item_t          s_payload,
    output iisb_pkg::store_req_t             req,
    input  wire logic [iisb_pkg::WORD_W-1:0] rd_data,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output iisb_pkg::out_item_t              res
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_PUT    = 5'b00100,
        S_REMOVE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t                            state_reg, state_next;
    logic [iisb_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [iisb_pkg::ADDR_W-1:0]       ptr_reg, ptr_next;
    logic [iisb_pkg::ADDR_W-1:0]       idx_reg, idx_next;
    logic [iisb_pkg::WORD_W-1:0]       word_reg, word_next;
    logic [iisb_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [iisb_pkg::WORD_W-1:0]       removed_reg, removed_next;

    logic [iisb_pkg::CMP_W-1:0]  idx_ext;
    logic [iisb_pkg::CMP_W-1:0]  cnt_ext;
    logic                        in_range;
    logic                        full;
    logic                        take;
    logic [iisb_pkg::ADDR_W-1:0] ptr_m1;
    logic [iisb_pkg::ADDR_W-1:0] cnt_m1;

    assign s_ready   = (state_reg == S_IDLE);
    assign take      = s_valid && s_ready;
    assign idx_ext   = iisb_pkg::CMP_W'(s_payload.slot_index);
    assign cnt_ext   = iisb_pkg::CMP_W'(count_reg);
    assign in_range  = idx_ext < iisb_pkg::CMP_W'(iisb_pkg::CAPACITY);
    assign full      = count_reg == iisb_pkg::CNT_W'(iisb_pkg::CAPACITY);
    assign ptr_m1    = ptr_reg - iisb_pkg::ADDR_W'(1);
    assign cnt_m1    = iisb_pkg::ADDR_W'(count_reg - iisb_pkg::CNT_W'(1));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        word_next    = word_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        req          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (take) begin
                    status_next  = iisb_pkg::ST_OK;
                    removed_next = '0;
                    state_next   = S_EMIT;
                    priority if (s_payload.operation == iisb_pkg::OP_APPEND ||
                                 (s_payload.operation == iisb_pkg::OP_INSERT &&
                                  in_range && idx_ext == cnt_ext)) begin
                        if (full) begin
                            status_next = iisb_pkg::ST_FULL;
                        end else begin
                            req.wr_en   = 1'b1;
                            req.wr_addr = iisb_pkg::ADDR_W'(count_reg);
                            req.wr_data = s_payload.value;
                            count_next  = count_reg + iisb_pkg::CNT_W'(1);
                        end
                    end else if (s_payload.operation == iisb_pkg::OP_INSERT) begin
                        if (!in_range) begin
                            status_next = iisb_pkg::ST_RANGE;
                        end else if (idx_ext > cnt_ext) begin
                            // Beyond the used part: write in place, leave the gap
                            req.wr_en   = 1'b1;
                            req.wr_addr = iisb_pkg::ADDR_W'(s_payload.slot_index);
                            req.wr_data = s_payload.value;
                            count_next  = iisb_pkg::CNT_W'(s_payload.slot_index)
                                          + iisb_pkg::CNT_W'(1);
                        end else if (full) begin
                            status_next = iisb_pkg::ST_FULL;
                        end else begin
                            // Inside the used part: fetch the top entry, start the shift
                            req.rd_en   = 1'b1;
                            req.rd_addr = cnt_m1;
                            ptr_next    = iisb_pkg::ADDR_W'(count_reg);
                            idx_next    = iisb_pkg::ADDR_W'(s_payload.slot_index);
                            word_next   = s_payload.value;
                            state_next  = S_SHIFT;
                        end
                    end else if (s_payload.operation == iisb_pkg::OP_REMOVE) begin
                        if (count_reg == '0) begin
                            status_next = iisb_pkg::ST_EMPTY;
                        end else begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = cnt_m1;
                            count_next  = count_reg - iisb_pkg::CNT_W'(1);
                            state_next  = S_REMOVE;
                        end
                    end else begin
                        status_next = iisb_pkg::ST_OK;
                    end
                end
            end
            S_SHIFT: begin
                // Move the fetched entry up one place; fetch the next one down until the slot is reached
                req.wr_en   = 1'b1;
                req.wr_addr = ptr_reg;
                req.wr_data = rd_data;
                if (ptr_m1 == idx_reg) begin
                    state_next = S_PUT;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = ptr_m1 - iisb_pkg::ADDR_W'(1);
                    ptr_next    = ptr_m1;
                end
            end
            S_PUT: begin
                req.wr_en   = 1'b1;
                req.wr_addr = idx_reg;
                req.wr_data = word_reg;
                count_next  = count_reg + iisb_pkg::CNT_W'(1);
                state_next  = S_EMIT;
            end
            S_REMOVE: begin
                removed_next = rd_data;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        word_reg    <= word_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    assign res_valid         = (state_reg == S_EMIT);
    assign res.status        = status_reg;
    assign res.removed_value = removed_reg;
    assign res.element_count = iisb_pkg::ECOUNT_W'(count_reg);

endmodule

`default_nettype wire

// ----- rtl/indexed_insert_stack_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  in_item_t  (operation, slot_index, value)
// m_        out        m_valid / m_ready  out_item_t (status, removed_value, element_count)
//
// One transaction in gives one transaction out. Append, insert past the used part,
// no-op and rejected transactions go straight to the result; remove first captures
// the read top entry; insert inside the used part moves (count - slot_index) entries,
// one per cycle (the store reads one entry, writes the one above), then writes the value.
// Reset clears the count and the per-entry written flags at once; no clearing pass.
// A result waiting on m_ready blocks the next transaction only once that one finishes.

module indexed_insert_stack_buffer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire iisb_pkg::in_item_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output iisb_pkg::out_item_t      m_payload
);

    iisb_pkg::store_req_t         req;
    logic [iisb_pkg::WORD_W-1:0]  rd_data;
    logic                         res_valid;
    logic                         res_ready;
    iisb_pkg::out_item_t          res;

    logic                         m_valid_reg, m_valid_next;
    iisb_pkg::out_item_t          m_payload_reg, m_payload_next;

    // Word store: memory plus written flags
    iisb_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_data (rd_data)
    );

    // Operation sequencer: decode, shift, remove, count
    iisb_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .req       (req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (res_valid && res_ready) begin
            // advance the finished result into the output register
            m_valid_next   = 1'b1;
            m_payload_next = res;
        end else if (m_ready) begin
            // drop the delivered result
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload until it is taken
    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire
